FILE: src/pwr_pkg.sv
// package: shared constants and types of the primality witness round
package pwr_pkg;

   localparam int NUM_WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH = 32;

   typedef enum logic [1:0] {
      VERDICT_PASS      = 2'd0,
      VERDICT_COMPOSITE = 2'd1,
      VERDICT_INVALID   = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_SQ,
      ST_MM,
      ST_EVAL,
      ST_DONE
   } state_type;

endpackage

FILE: src/primality_witness_round.sv
// top level: one miller-rabin witness round over a shared modular adder
// sequence: invalid operands go straight to the response, otherwise binary gcd, then per
// exponent tried W squarings, one multiply per set exponent bit and one check (W = NUM_WIDTH)
// throughput: one transaction at a time, next request taken in the cycle after the response
// is accepted
// reset: synchronous, returns the sequencer to idle and drops the response valid
module primality_witness_round #(
   parameter int NUM_WIDTH = pwr_pkg::NUM_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pwr_pkg::FIELD_WIDTH-1:0]   req_candidate,
   input  logic [pwr_pkg::FIELD_WIDTH-1:0]   req_witness,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_verdict
);

   localparam int W  = NUM_WIDTH;
   localparam int BW = $clog2(W);
   localparam int FW = pwr_pkg::FIELD_WIDTH;

   pwr_pkg::state_type state_ff, state_in;

   logic [W-1:0]  n_ff, n_in, a_ff, a_in, u_ff, u_in, v_ff, v_in;
   logic [W-1:0]  e_ff, e_in, r_ff, r_in, acc_ff, acc_in, mx_ff, mx_in, my_ff, my_in;
   logic [BW-1:0] ebit_ff, ebit_in, mbit_ff, mbit_in;
   logic          mphase_ff, mphase_in, pmul_ff, pmul_in;
   pwr_pkg::verdict_type verdict_ff, verdict_in;

   logic [W+FW-1:0] cand_ext, wit_ext;
   logic [W-1:0]    cand_w, wit_w;
   logic            invalid;

   // shared modular adder
   logic [W-1:0] add_q, add_room, add_res;
   logic         mm_last;

   assign cand_ext = {{W{1'b0}}, req_candidate};
   assign wit_ext  = {{W{1'b0}}, req_witness};
   assign cand_w   = cand_ext[W-1:0];
   assign wit_w    = wit_ext[W-1:0];
   assign invalid  = (cand_w < W'(3)) || (wit_w < W'(2)) || (wit_w >= cand_w);

   assign add_q    = mphase_ff ? mx_ff : acc_ff;
   assign add_room = n_ff - add_q;
   assign add_res  = (acc_ff >= add_room) ? (acc_ff - add_room) : (acc_ff + add_q);
   assign mm_last  = (mbit_ff == '0) && (mphase_ff || !my_ff[mbit_ff]);

   assign req_ready   = (state_ff == pwr_pkg::ST_IDLE);
   assign rsp_valid   = (state_ff == pwr_pkg::ST_DONE);
   assign rsp_verdict = verdict_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pwr_pkg::ST_IDLE: begin
            if (req_valid) state_in = invalid ? pwr_pkg::ST_DONE : pwr_pkg::ST_GCD;
         end
         pwr_pkg::ST_GCD: begin
            if (u_ff == '0) state_in = (v_ff == W'(1)) ? pwr_pkg::ST_SQ : pwr_pkg::ST_DONE;
            else if (!u_ff[0] && !v_ff[0]) state_in = pwr_pkg::ST_DONE;
         end
         pwr_pkg::ST_SQ: state_in = pwr_pkg::ST_MM;
         pwr_pkg::ST_MM: begin
            if (mm_last && !(!pmul_ff && e_ff[ebit_ff])) begin
               state_in = (ebit_ff == '0) ? pwr_pkg::ST_EVAL : pwr_pkg::ST_SQ;
            end
         end
         pwr_pkg::ST_EVAL: begin
            if ((r_ff == n_ff - W'(1)) || (r_ff != W'(1)) || e_ff[0]) state_in = pwr_pkg::ST_DONE;
            else state_in = pwr_pkg::ST_SQ;
         end
         pwr_pkg::ST_DONE: begin
            if (rsp_ready) state_in = pwr_pkg::ST_IDLE;
         end
         default: state_in = pwr_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      n_in = n_ff; a_in = a_ff; u_in = u_ff; v_in = v_ff; e_in = e_ff; r_in = r_ff;
      acc_in = acc_ff; mx_in = mx_ff; my_in = my_ff; ebit_in = ebit_ff; mbit_in = mbit_ff;
      mphase_in = mphase_ff; pmul_in = pmul_ff; verdict_in = verdict_ff;
      case (state_ff)
         pwr_pkg::ST_IDLE: begin
            n_in = cand_w;
            a_in = wit_w;
            u_in = wit_w;
            v_in = cand_w;
            r_in = W'(1);
            ebit_in = BW'(W - 1);
            verdict_in = pwr_pkg::VERDICT_INVALID;
         end
         pwr_pkg::ST_GCD: begin
            e_in = n_ff - W'(1);
            if (u_ff == '0) begin
               verdict_in = pwr_pkg::VERDICT_COMPOSITE;
            end else if (!u_ff[0] && !v_ff[0]) begin
               verdict_in = pwr_pkg::VERDICT_COMPOSITE;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff >= v_ff) begin
               u_in = u_ff - v_ff;
            end else begin
               v_in = v_ff - u_ff;
            end
         end
         pwr_pkg::ST_SQ: begin
            acc_in = '0;
            mx_in = r_ff;
            my_in = r_ff;
            mbit_in = BW'(W - 1);
            mphase_in = 1'b0;
            pmul_in = 1'b0;
         end
         pwr_pkg::ST_MM: begin
            acc_in = add_res;
            if (!mphase_ff && my_ff[mbit_ff]) begin
               mphase_in = 1'b1;
            end else if (mbit_ff != '0) begin
               mbit_in = mbit_ff - BW'(1);
               mphase_in = 1'b0;
            end else begin
               r_in = add_res;
               mphase_in = 1'b0;
               if (!pmul_ff && e_ff[ebit_ff]) begin
                  acc_in = '0;
                  mx_in = add_res;
                  my_in = a_ff;
                  mbit_in = BW'(W - 1);
                  pmul_in = 1'b1;
               end else if (ebit_ff != '0) begin
                  ebit_in = ebit_ff - BW'(1);
               end
            end
         end
         pwr_pkg::ST_EVAL: begin
            if (r_ff == n_ff - W'(1)) begin
               verdict_in = pwr_pkg::VERDICT_PASS;
            end else if (r_ff != W'(1)) begin
               verdict_in = pwr_pkg::VERDICT_COMPOSITE;
            end else if (e_ff[0]) begin
               verdict_in = pwr_pkg::VERDICT_PASS;
            end else begin
               e_in = e_ff >> 1;
               r_in = W'(1);
               ebit_in = BW'(W - 1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pwr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff <= n_in; a_ff <= a_in; u_ff <= u_in; v_ff <= v_in; e_ff <= e_in; r_ff <= r_in;
      acc_ff <= acc_in; mx_ff <= mx_in; my_ff <= my_in; ebit_ff <= ebit_in;
      mbit_ff <= mbit_in; mphase_ff <= mphase_in; pmul_ff <= pmul_in;
      verdict_ff <= verdict_in;
   end

endmodule
